### src/lpp_pkg.sv
// lpp_pkg: shared types and constants for the lidar packet parser
`default_nettype none
package lpp_pkg;

  localparam int unsigned ANGLE_BINS_DEF  = 360;
  localparam logic [7:0]  HDR_FIRST       = 8'hAA;
  localparam logic [7:0]  HDR_SECOND      = 8'h55;
  localparam int unsigned TYPE_SKIP_BIT   = 0;
  localparam logic [13:0] MAX_DEPTH_RESET = 14'd1000;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ANGLE_W  = 9;
  localparam int unsigned DIST_W   = 14;
  localparam int unsigned BINS_W   = 10;
  // reciprocal multiply for the angle modulo, exact for 9-bit dividends
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned RECIP_W     = 20;

  typedef enum logic [3:0] {
    PH_HUNT1   = 4'd0,
    PH_HUNT2   = 4'd1,
    PH_TYPE    = 4'd2,
    PH_COUNT   = 4'd3,
    PH_FSA_LO  = 4'd4,
    PH_FSA_HI  = 4'd5,
    PH_LSA_LO  = 4'd6,
    PH_LSA_HI  = 4'd7,
    PH_CS_LO   = 4'd8,
    PH_CS_HI   = 4'd9,
    PH_SAMP_LO = 4'd10,
    PH_SAMP_HI = 4'd11
  } phase_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_deg;
    logic [DIST_W-1:0]  distance;
    logic               last_of_packet;
  } result_t;

endpackage
`default_nettype wire

### src/lpp_angle_mod.sv
// lpp_angle_mod: first angle in whole degrees reduced modulo the bin count
`default_nettype none
module lpp_angle_mod #(
  parameter int unsigned ANGLE_BINS = lpp_pkg::ANGLE_BINS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        load,
  input  wire logic [lpp_pkg::ANGLE_W-1:0] deg_in,
  output logic      [lpp_pkg::ANGLE_W-1:0] base_angle
);

  localparam int unsigned RECIP =
    ((1 << lpp_pkg::RECIP_SHIFT) + ANGLE_BINS - 1) / ANGLE_BINS;
  localparam int unsigned PROD_W = lpp_pkg::ANGLE_W + lpp_pkg::RECIP_W;
  localparam int unsigned QB_W   = lpp_pkg::ANGLE_W + lpp_pkg::BINS_W;

  logic [lpp_pkg::ANGLE_W-1:0] deg_r, deg1_r, deg2_r, base_r;
  logic [PROD_W-1:0]           prod_r;
  logic [QB_W-1:0]             qb_r;
  logic [lpp_pkg::ANGLE_W-1:0] quot;

  // quotient is below 512, so bit 28 of the product is always clear
  assign quot = prod_r[lpp_pkg::RECIP_SHIFT +: lpp_pkg::ANGLE_W];

  // free-running: after a load the angle passes through prod_r, qb_r and
  // base_r; the parser picks it up on the checksum high byte, no sooner than base_r holds it
  always_ff @(posedge clk) begin
    if (load) begin
      deg_r <= deg_in;
    end
    prod_r <= PROD_W'(deg_r) * PROD_W'(lpp_pkg::RECIP_W'(RECIP));
    deg1_r <= deg_r;
    qb_r   <= QB_W'(quot) * QB_W'(lpp_pkg::BINS_W'(ANGLE_BINS));
    deg2_r <= deg1_r;
    base_r <= deg2_r - qb_r[lpp_pkg::ANGLE_W-1:0];
  end

  assign base_angle = base_r;

endmodule
`default_nettype wire

### src/lpp_fsm.sv
// lpp_fsm: byte-level packet parser and per-sample result formation
`default_nettype none
module lpp_fsm #(
  parameter int unsigned ANGLE_BINS = lpp_pkg::ANGLE_BINS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        beat,
  input  wire logic [lpp_pkg::BYTE_W-1:0]  rx_byte,
  input  wire logic [lpp_pkg::DIST_W-1:0]  max_depth,
  input  wire logic [lpp_pkg::ANGLE_W-1:0] base_angle,
  output logic                             fsa_load,
  output logic      [lpp_pkg::ANGLE_W-1:0] fsa_deg,
  output logic                             res_vld,
  output lpp_pkg::result_t                 res
);

  localparam logic [lpp_pkg::ANGLE_W-1:0] ANGLE_TOP = lpp_pkg::ANGLE_W'(ANGLE_BINS - 1);

  lpp_pkg::phase_t             phase_r, phase_nxt;
  logic [7:0]                  total_r, total_nxt;
  logic [7:0]                  index_r, index_nxt;
  logic [7:0]                  hold_r, hold_nxt;
  logic [lpp_pkg::ANGLE_W-1:0] angle_r, angle_nxt;
  logic                        is_last;
  logic [lpp_pkg::DIST_W-1:0]  dist_raw;

  assign is_last  = ({1'b0, index_r} + 9'd1) >= {1'b0, total_r};
  assign dist_raw = {rx_byte, hold_r[7:2]};
  assign fsa_deg  = {rx_byte, hold_r[7]};

  // next state
  always_comb begin
    phase_nxt = phase_r;
    total_nxt = total_r;
    index_nxt = index_r;
    hold_nxt  = hold_r;
    angle_nxt = angle_r;
    if (beat) begin
      case (phase_r)
        lpp_pkg::PH_HUNT1: begin
          if (rx_byte == lpp_pkg::HDR_FIRST) phase_nxt = lpp_pkg::PH_HUNT2;
        end
        lpp_pkg::PH_HUNT2: begin
          if (rx_byte == lpp_pkg::HDR_SECOND) phase_nxt = lpp_pkg::PH_TYPE;
          else if (rx_byte != lpp_pkg::HDR_FIRST) phase_nxt = lpp_pkg::PH_HUNT1;
        end
        lpp_pkg::PH_TYPE: begin
          phase_nxt = rx_byte[lpp_pkg::TYPE_SKIP_BIT] ? lpp_pkg::PH_HUNT1 : lpp_pkg::PH_COUNT;
        end
        lpp_pkg::PH_COUNT: begin
          total_nxt = rx_byte;
          index_nxt = '0;
          phase_nxt = (rx_byte == 8'd0) ? lpp_pkg::PH_HUNT1 : lpp_pkg::PH_FSA_LO;
        end
        lpp_pkg::PH_FSA_LO: begin
          hold_nxt  = rx_byte;
          phase_nxt = lpp_pkg::PH_FSA_HI;
        end
        lpp_pkg::PH_FSA_HI:  phase_nxt = lpp_pkg::PH_LSA_LO;
        lpp_pkg::PH_LSA_LO:  phase_nxt = lpp_pkg::PH_LSA_HI;
        lpp_pkg::PH_LSA_HI:  phase_nxt = lpp_pkg::PH_CS_LO;
        lpp_pkg::PH_CS_LO:   phase_nxt = lpp_pkg::PH_CS_HI;
        lpp_pkg::PH_CS_HI: begin
          index_nxt = '0;
          angle_nxt = base_angle;
          phase_nxt = lpp_pkg::PH_SAMP_LO;
        end
        lpp_pkg::PH_SAMP_LO: begin
          hold_nxt  = rx_byte;
          phase_nxt = lpp_pkg::PH_SAMP_HI;
        end
        lpp_pkg::PH_SAMP_HI: begin
          index_nxt = index_r + 8'd1;
          angle_nxt = (angle_r == ANGLE_TOP) ? '0 : angle_r + 1'b1;
          phase_nxt = is_last ? lpp_pkg::PH_HUNT1 : lpp_pkg::PH_SAMP_LO;
        end
        default: phase_nxt = lpp_pkg::PH_HUNT1;
      endcase
    end
  end

  // outputs
  always_comb begin
    fsa_load           = 1'b0;
    res_vld            = 1'b0;
    res.angle_deg      = angle_r;
    res.distance       = (dist_raw >= max_depth) ? '0 : dist_raw;
    res.last_of_packet = is_last;
    case (phase_r)
      lpp_pkg::PH_FSA_HI:  fsa_load = beat;
      lpp_pkg::PH_SAMP_HI: res_vld  = beat;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lpp_pkg::PH_HUNT1;
      total_r <= '0;
      index_r <= '0;
      hold_r  <= '0;
      angle_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      total_r <= total_nxt;
      index_r <= index_nxt;
      hold_r  <= hold_nxt;
      angle_r <= angle_nxt;
    end
  end

endmodule
`default_nettype wire

### src/lidar_packet_parser.sv
// lidar_packet_parser: top level, scan packet bytes in, angle/distance samples out
//
//   channel | dir | beat fields
//   --------+-----+---------------------------------------------------------
//   in_     | in  | tdata[7:0] rx_byte
//   out_    | out | tdata[8:0] angle_deg, [22:9] distance; tlast last_of_packet
//   cfg_    | in  | wr_data[13:0] max_depth, written when wr_en high
//
// One byte per cycle while in_tready is high: each accepted byte passes
// through the parser logic and, on a sample's second byte, lands in the
// output register, so the result is on out_ the cycle after that byte's beat.
// The output register frees in the same cycle it is taken, so in_tready
// only drops while a result is held against a low out_tready.
// The angle modulo runs in a side pipeline (prod_r, qb_r, base_r) whose
// result is ready by the earliest cycle the checksum high byte can be taken,
// which is where the parser picks it up. Synchronous active-low reset; max_depth
// returns to 1000 and the parser goes back to hunting for the header.
`default_nettype none
module lidar_packet_parser #(
  parameter int unsigned ANGLE_BINS = lpp_pkg::ANGLE_BINS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,    // [8:0] angle_deg, [22:9] distance, [23] zero
  output logic             out_tlast,
  input  wire logic        cfg_wr_en,
  input  wire logic [13:0] cfg_wr_data   // [13:0] max_depth
);

  logic                             in_beat;
  logic [lpp_pkg::DIST_W-1:0]       max_depth_r;
  logic [lpp_pkg::ANGLE_W-1:0]      base_angle;
  logic                             fsa_load;
  logic [lpp_pkg::ANGLE_W-1:0]      fsa_deg;
  logic                             res_vld;
  lpp_pkg::result_t                 res;
  logic                             out_vld_r, out_vld_nxt;
  lpp_pkg::result_t                 out_res_r;

  // output slot is free or being emptied this cycle
  assign in_tready = !out_vld_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_depth_r <= lpp_pkg::MAX_DEPTH_RESET;
    end else if (cfg_wr_en) begin
      max_depth_r <= cfg_wr_data;
    end
  end

  lpp_angle_mod #(
    .ANGLE_BINS (ANGLE_BINS)
  ) u_angle (
    .clk        (clk),
    .load       (fsa_load),
    .deg_in     (fsa_deg),
    .base_angle (base_angle)
  );

  lpp_fsm #(
    .ANGLE_BINS (ANGLE_BINS)
  ) u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat       (in_beat),
    .rx_byte    (in_tdata),
    .max_depth  (max_depth_r),
    .base_angle (base_angle),
    .fsa_load   (fsa_load),
    .fsa_deg    (fsa_deg),
    .res_vld    (res_vld),
    .res        (res)
  );

  // result register: load on a new sample, clear when taken
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (in_beat) begin
      out_vld_nxt = res_vld;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_res_r.distance, out_res_r.angle_deg};
  assign out_tlast  = out_res_r.last_of_packet;

  // a sample byte always leaves a result behind
  a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && res_vld |=> out_tvalid)
    else $error("sample result not registered");

  // angle bin stays inside the configured range
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[8:0]) < ANGLE_BINS))
    else $error("angle bin out of range");

  // a byte that makes no result empties a drained output slot
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && !res_vld |=> !out_tvalid)
    else $error("result appeared without a sample byte");

endmodule
`default_nettype wire
